// ----- hw/rtl/flms_pkg.sv -----
// shared types, constants and record helpers for the flash log mode store
`timescale 1ns / 1ps

package flms_pkg;

   localparam int unsigned PAGE_DEPTH_DEF = 512;

   localparam int unsigned WORD_W = 16;
   localparam int unsigned MODE_W = 4;
   localparam int unsigned IN_W   = 8;
   localparam int unsigned CSR_IW = 2;

   localparam logic [WORD_W-1:0] HEADER_WORD = 16'h5AA5;
   localparam logic [WORD_W-1:0] MAGIC_WORD  = 16'hA500;
   localparam logic [WORD_W-1:0] MAGIC_MASK  = 16'hFF00;
   localparam logic [MODE_W-1:0] NIBBLE      = 4'hF;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_SAVE = 1'b1;

   localparam logic [CSR_IW-1:0] CSR_MIN_MODE      = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_MAX_MODE      = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_FALLBACK_MODE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_APPEND
   } state_type;

   function automatic logic mode_ok(input logic [MODE_W-1:0] lo,
                                    input logic [MODE_W-1:0] hi,
                                    input logic [IN_W-1:0]   m);
      logic [IN_W-1:0] lo_x;
      logic [IN_W-1:0] hi_x;
      lo_x = {{(IN_W-MODE_W){1'b0}}, lo};
      hi_x = {{(IN_W-MODE_W){1'b0}}, hi};
      return (m >= lo_x) && (m <= hi_x);
   endfunction

   function automatic logic [WORD_W-1:0] record_encode(input logic [MODE_W-1:0] m);
      return MAGIC_WORD | {8'h00, ~m, m};
   endfunction

   function automatic logic record_valid(input logic [WORD_W-1:0] rec,
                                         input logic [MODE_W-1:0] lo,
                                         input logic [MODE_W-1:0] hi);
      logic magic_ok;
      logic chk_ok;
      magic_ok = (rec & MAGIC_MASK) == MAGIC_WORD;
      chk_ok   = (rec[7:4] ^ rec[3:0]) == NIBBLE;
      return magic_ok && chk_ok && mode_ok(lo, hi, {4'h0, rec[3:0]});
   endfunction

endpackage

// ----- hw/rtl/flms_ram.sv -----
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps

module flms_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 512,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/flash_log_mode_store_top.sv -----
// load: no records answers from idle, else one ram read per record in scan, then drain
// save: answers from idle, or via the append state when the page is erased and re-headed
// one request at a time; a new request is taken once the previous response has left
// reset: config to defaults, last mode 0, fill count 0 so the page reads as erased;
// ram contents stay undefined and are never read before being written, no clearing pass
`timescale 1ns / 1ps

module flash_log_mode_store_top #(
   parameter int unsigned PAGE_DEPTH = flms_pkg::PAGE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_operation,
   input  logic [flms_pkg::IN_W-1:0]     req_mode_value,
   input  logic [flms_pkg::IN_W-1:0]     req_default_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [flms_pkg::MODE_W-1:0]   rsp_result_mode,
   output logic                          rsp_success,
   output logic                          rsp_page_erased,
   input  logic                          csr_write_en,
   input  logic [flms_pkg::CSR_IW-1:0]   csr_index,
   input  logic [flms_pkg::MODE_W-1:0]   csr_wdata
);

   localparam int unsigned AW = $clog2(PAGE_DEPTH);
   localparam int unsigned FW = $clog2(PAGE_DEPTH + 1);
   localparam int unsigned MW = flms_pkg::MODE_W;
   localparam int unsigned WW = flms_pkg::WORD_W;

   flms_pkg::state_type state_ff, state_in;

   logic [MW-1:0] min_ff, min_in;
   logic [MW-1:0] max_ff, max_in;
   logic [MW-1:0] fb_ff, fb_in;
   logic [MW-1:0] last_ff, last_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic          rd_pend_ff, rd_pend_in;
   logic [MW-1:0] m_ff, m_in;
   logic [MW-1:0] mval_ff, mval_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [MW-1:0] rsp_mode_ff, rsp_mode_in;
   logic          rsp_ok_ff, rsp_ok_in;
   logic          rsp_erased_ff, rsp_erased_in;

   logic          req_fire;
   logic          need_erase;
   logic          has_records;
   logic          save_ok;
   logic          save_same;
   logic          rec_ok;
   logic [MW-1:0] dflt_mode;
   logic [MW-1:0] scan_mode;
   logic [AW-1:0] last_idx;
   logic [FW-1:0] fill_dec;

   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [WW-1:0] ram_wr_data;
   logic          ram_rd_en;
   logic [WW-1:0] ram_rd_data;

   flms_ram #(
      .WIDTH (WW),
      .DEPTH (PAGE_DEPTH)
   ) u_page (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   assign req_ready = (state_ff == flms_pkg::ST_IDLE) && !rsp_valid_ff;
   assign req_fire  = req_valid && req_ready;

   assign need_erase  = (fill_ff == '0) || (fill_ff == FW'(PAGE_DEPTH));
   assign has_records = fill_ff >= FW'(2);
   assign fill_dec    = fill_ff - FW'(1);
   assign last_idx    = fill_dec[AW-1:0];
   assign save_ok     = flms_pkg::mode_ok(min_ff, max_ff, req_mode_value);
   assign save_same   = req_mode_value == {4'h0, last_ff};
   assign dflt_mode   = flms_pkg::mode_ok(min_ff, max_ff, req_default_value) ?
                        req_default_value[MW-1:0] : fb_ff;
   assign rec_ok      = flms_pkg::record_valid(ram_rd_data, min_ff, max_ff);
   assign scan_mode   = (rd_pend_ff && rec_ok) ? ram_rd_data[MW-1:0] : m_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         flms_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_operation == flms_pkg::OP_LOAD) begin
                  if (has_records) begin
                     state_in = flms_pkg::ST_SCAN;
                  end
               end else if (save_ok && !save_same && need_erase) begin
                  state_in = flms_pkg::ST_APPEND;
               end
            end
         end
         flms_pkg::ST_SCAN: begin
            if (addr_ff == last_idx) begin
               state_in = flms_pkg::ST_DRAIN;
            end
         end
         flms_pkg::ST_DRAIN:  state_in = flms_pkg::ST_IDLE;
         flms_pkg::ST_APPEND: state_in = flms_pkg::ST_IDLE;
         default:             state_in = flms_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      min_in        = min_ff;
      max_in        = max_ff;
      fb_in         = fb_ff;
      last_in       = last_ff;
      fill_in       = fill_ff;
      addr_in       = addr_ff;
      m_in          = scan_mode;
      mval_in       = mval_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_mode_in   = rsp_mode_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_erased_in = rsp_erased_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = fill_ff[AW-1:0];
      ram_wr_data   = flms_pkg::record_encode(req_mode_value[MW-1:0]);
      ram_rd_en     = 1'b0;
      rd_pend_in    = 1'b0;

      if (csr_write_en) begin
         unique case (csr_index)
            flms_pkg::CSR_MIN_MODE:      min_in = csr_wdata;
            flms_pkg::CSR_MAX_MODE:      max_in = csr_wdata;
            flms_pkg::CSR_FALLBACK_MODE: fb_in  = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         flms_pkg::ST_IDLE: begin
            if (req_fire) begin
               rsp_erased_in = 1'b0;
               if (req_operation == flms_pkg::OP_LOAD) begin
                  m_in    = dflt_mode;
                  addr_in = AW'(1);
                  if (!has_records) begin
                     last_in      = dflt_mode;
                     rsp_valid_in = 1'b1;
                     rsp_mode_in  = dflt_mode;
                     rsp_ok_in    = 1'b1;
                  end
               end else if (!save_ok) begin
                  rsp_valid_in = 1'b1;
                  rsp_mode_in  = last_ff;
                  rsp_ok_in    = 1'b0;
               end else if (save_same) begin
                  rsp_valid_in = 1'b1;
                  rsp_mode_in  = last_ff;
                  rsp_ok_in    = 1'b1;
               end else if (need_erase) begin
                  // re-head the page, record follows next cycle
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = '0;
                  ram_wr_data = flms_pkg::HEADER_WORD;
                  fill_in     = FW'(1);
                  mval_in     = req_mode_value[MW-1:0];
               end else begin
                  ram_wr_en    = 1'b1;
                  fill_in      = fill_ff + FW'(1);
                  last_in      = req_mode_value[MW-1:0];
                  rsp_valid_in = 1'b1;
                  rsp_mode_in  = req_mode_value[MW-1:0];
                  rsp_ok_in    = 1'b1;
               end
            end
         end
         flms_pkg::ST_SCAN: begin
            ram_rd_en  = 1'b1;
            rd_pend_in = 1'b1;
            addr_in    = addr_ff + AW'(1);
         end
         flms_pkg::ST_DRAIN: begin
            last_in       = scan_mode;
            rsp_valid_in  = 1'b1;
            rsp_mode_in   = scan_mode;
            rsp_ok_in     = 1'b1;
            rsp_erased_in = 1'b0;
         end
         flms_pkg::ST_APPEND: begin
            ram_wr_en     = 1'b1;
            ram_wr_addr   = AW'(1);
            ram_wr_data   = flms_pkg::record_encode(mval_ff);
            fill_in       = FW'(2);
            last_in       = mval_ff;
            rsp_valid_in  = 1'b1;
            rsp_mode_in   = mval_ff;
            rsp_ok_in     = 1'b1;
            rsp_erased_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= flms_pkg::ST_IDLE;
         min_ff       <= '0;
         max_ff       <= flms_pkg::NIBBLE;
         fb_ff        <= '0;
         last_ff      <= '0;
         fill_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         fb_ff        <= fb_in;
         last_ff      <= last_in;
         fill_ff      <= fill_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      m_ff          <= m_in;
      mval_ff       <= mval_in;
      rsp_mode_ff   <= rsp_mode_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_erased_ff <= rsp_erased_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_mode = rsp_mode_ff;
   assign rsp_success     = rsp_ok_ff;
   assign rsp_page_erased = rsp_erased_ff;

endmodule
